// File: rtl/lcadc_pkg.sv
// shared types, constants and helper functions for the load cell adc reader
// no dependencies; imported by lcadc_ctrl, lcadc_dp and the top level
`timescale 1ns / 1ps
`default_nettype none

package lcadc_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int DATA_BITS    = 24;
    localparam int CH_W         = 3;
    localparam int CNT_W        = 4;
    localparam int BIT_CNT_W    = 5;
    localparam int WEIGHT_W     = DATA_BITS + 1;
    localparam int TOL_W        = 16;
    localparam int SAMP_W       = 8;
    localparam int GAIN_W       = 2;
    localparam int REQ_W        = 2;
    localparam int CFG_ADDR_W   = 2;
    localparam int CFG_DATA_W   = 16;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 32;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_TICK  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TARE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PDOWN = 2'd2;
    localparam logic [REQ_W-1:0] REQ_PUP   = 2'd3;

    // register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_CHANNEL_COUNT  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_GAIN_CODE      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARE_SAMPLES   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_TARE_TOLERANCE = 2'd3;

    // gain codes
    localparam logic [GAIN_W-1:0] GAIN_128     = 2'd0;
    localparam logic [GAIN_W-1:0] GAIN_64      = 2'd1;
    localparam logic [GAIN_W-1:0] GAIN_32      = 2'd2;
    localparam logic [GAIN_W-1:0] GAIN_INVALID = 2'd3;

    localparam logic [DATA_BITS-1:0] BOUND_TOP = {1'b0, {(DATA_BITS-1){1'b1}}};
    localparam logic [DATA_BITS-1:0] BOUND_BOT = {1'b1, {(DATA_BITS-1){1'b0}}};

    typedef struct packed {
        logic                    shift;
        logic [MAX_CHANNELS-1:0] lane_en;
        logic                    clear_bounds;
        logic                    clear_fail;
        logic                    scan;
        logic                    upd_bounds;
        logic                    idle_load;
        logic                    emit_load;
        logic                    wr_offset;
        logic [CH_W-1:0]         idx;
        logic                    sck;
        logic                    tare_done;
        logic                    tare_ok;
        logic                    last;
        logic [TOL_W-1:0]        tol;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
        logic spread_fail;
    } t_dp_stat;

    function automatic logic [CNT_W-1:0] f_active_count(input logic [CNT_W-1:0] cnt);
        logic [CNT_W-1:0] n;
        n = cnt;
        if (n == '0) n = CNT_W'(1);
        if (n > CNT_W'(MAX_CHANNELS)) n = CNT_W'(MAX_CHANNELS);
        return n;
    endfunction

    function automatic logic [MAX_CHANNELS-1:0] f_lane_mask(input logic [CNT_W-1:0] n);
        logic [MAX_CHANNELS-1:0] m;
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            m[k] = (CNT_W'(k) < n);
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// File: rtl/lcadc_ctrl.sv
// controller: configuration registers, serial clock sequencer, tare bookkeeping
// and the scan / emit pass sequencing; uses lcadc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcadc_ctrl import lcadc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]   i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                    i_s_tvalid,
    output logic                         o_s_tready,
    input  wire logic [REQ_W-1:0]        i_req,
    input  wire logic [MAX_CHANNELS-1:0] i_lines,
    input  wire t_dp_stat                i_stat,
    output t_dp_cmd                      o_cmd
);

    localparam logic [2:0] PH_IDLE      = 3'd0;
    localparam logic [2:0] PH_DATA_HIGH = 3'd1;
    localparam logic [2:0] PH_DATA_LOW  = 3'd2;
    localparam logic [2:0] PH_GAIN_HIGH = 3'd3;
    localparam logic [2:0] PH_GAIN_LOW  = 3'd4;

    localparam logic [1:0] ST_TICK = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [CNT_W-1:0]     r_cfg_cnt;
    logic [GAIN_W-1:0]    r_cfg_gain;
    logic [SAMP_W-1:0]    r_cfg_samples;
    logic [TOL_W-1:0]     r_cfg_tol;

    logic [1:0]           r_state, n_state;
    logic [2:0]           r_phase, n_phase;
    logic                 r_clk_lvl, n_clk_lvl;
    logic [BIT_CNT_W-1:0] r_bit_cnt, n_bit_cnt;
    logic [1:0]           r_pulse_cnt, n_pulse_cnt;
    logic                 r_pd, n_pd;
    logic [SAMP_W-1:0]    r_tare_rem, n_tare_rem;
    logic                 r_tare_act, n_tare_act;
    logic                 r_done, n_done;
    logic                 r_upd, n_upd;
    logic [CH_W-1:0]      r_idx, n_idx;

    logic [2:0]           tk_phase;
    logic                 tk_clk;
    logic [BIT_CNT_W-1:0] tk_bit;
    logic [1:0]           tk_pulse;
    logic                 tk_pd;
    logic                 tk_shift;
    logic                 tk_fin;

    logic                 accept;
    logic [CNT_W-1:0]     n_active;
    logic [MAX_CHANNELS-1:0] lane_mask;
    logic [CH_W-1:0]      last_idx;
    logic [1:0]           pulses;
    logic [SAMP_W-1:0]    samples_eff;
    logic                 act_eff;
    logic [SAMP_W-1:0]    rem_eff;
    logic [SAMP_W-1:0]    rem_dec;
    logic                 tk_done;
    logic                 tare_ok;

    assign n_active    = f_active_count(r_cfg_cnt);
    assign lane_mask   = f_lane_mask(n_active);
    assign last_idx    = CH_W'(n_active - CNT_W'(1));
    assign pulses      = (r_cfg_gain == GAIN_64) ? 2'd3 : (r_cfg_gain == GAIN_32) ? 2'd2 : 2'd1;
    assign samples_eff = (r_cfg_samples == '0) ? SAMP_W'(1) : r_cfg_samples;
    assign o_s_tready  = (r_state == ST_TICK) && i_stat.out_free;
    assign accept      = i_s_tvalid && o_s_tready;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cnt     <= CNT_W'(1);
            r_cfg_gain    <= GAIN_128;
            r_cfg_samples <= SAMP_W'(10);
            r_cfg_tol     <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_CHANNEL_COUNT:  r_cfg_cnt <= i_cfg_data[CNT_W-1:0];
                CFG_GAIN_CODE: begin
                    if (i_cfg_data[GAIN_W-1:0] != GAIN_INVALID) begin
                        r_cfg_gain <= i_cfg_data[GAIN_W-1:0];
                    end
                end
                CFG_TARE_SAMPLES:   r_cfg_samples <= i_cfg_data[SAMP_W-1:0];
                CFG_TARE_TOLERANCE: r_cfg_tol <= i_cfg_data[TOL_W-1:0];
                default: ;
            endcase
        end
    end

    // one tick of the serial clock sequencer
    always_comb begin
        tk_phase = r_phase;
        tk_clk   = r_clk_lvl;
        tk_bit   = r_bit_cnt;
        tk_pulse = r_pulse_cnt;
        tk_pd    = r_pd;
        tk_shift = 1'b0;
        tk_fin   = 1'b0;
        if (i_req == REQ_PDOWN) begin
            tk_pd    = 1'b1;
            tk_phase = PH_IDLE;
            tk_bit   = '0;
            tk_pulse = '0;
            tk_clk   = 1'b1;
        end else if (r_pd) begin
            if (i_req == REQ_PUP) begin
                tk_pd    = 1'b0;
                tk_clk   = 1'b0;
                tk_phase = PH_IDLE;
                tk_bit   = '0;
                tk_pulse = '0;
            end else begin
                tk_clk = 1'b1;
            end
        end else begin
            case (r_phase)
                PH_DATA_HIGH: begin
                    tk_shift = 1'b1;
                    tk_bit   = r_bit_cnt + BIT_CNT_W'(1);
                    tk_clk   = 1'b0;
                    if (tk_bit >= BIT_CNT_W'(DATA_BITS)) begin
                        tk_pulse = '0;
                        tk_phase = PH_GAIN_LOW;
                    end else begin
                        tk_phase = PH_DATA_LOW;
                    end
                end
                PH_DATA_LOW: begin
                    tk_clk   = 1'b1;
                    tk_phase = PH_DATA_HIGH;
                end
                PH_GAIN_HIGH: begin
                    tk_clk   = 1'b0;
                    tk_pulse = r_pulse_cnt + 2'd1;
                    if (tk_pulse >= pulses) begin
                        tk_fin   = 1'b1;
                        tk_phase = PH_IDLE;
                        tk_bit   = '0;
                        tk_pulse = '0;
                    end else begin
                        tk_phase = PH_GAIN_LOW;
                    end
                end
                PH_GAIN_LOW: begin
                    tk_clk   = 1'b1;
                    tk_phase = PH_GAIN_HIGH;
                end
                default: begin
                    tk_clk   = 1'b0;
                    tk_phase = PH_IDLE;
                    if ((i_lines & lane_mask) == '0) begin
                        tk_clk   = 1'b1;
                        tk_bit   = '0;
                        tk_phase = PH_DATA_HIGH;
                    end
                end
            endcase
        end
    end

    // tare counting for this tick
    assign act_eff = (i_req == REQ_TARE) ? 1'b1 : r_tare_act;
    assign rem_eff = (i_req == REQ_TARE) ? samples_eff : r_tare_rem;
    assign rem_dec = (rem_eff != '0) ? rem_eff - SAMP_W'(1) : '0;
    assign tk_done = tk_fin && act_eff && (rem_dec == '0);
    assign tare_ok = r_done && !((r_cfg_tol != '0) && (r_cfg_samples > SAMP_W'(1))
                     && i_stat.spread_fail);

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_clk_lvl   = r_clk_lvl;
        n_bit_cnt   = r_bit_cnt;
        n_pulse_cnt = r_pulse_cnt;
        n_pd        = r_pd;
        n_tare_rem  = r_tare_rem;
        n_tare_act  = r_tare_act;
        n_done      = r_done;
        n_upd       = r_upd;
        n_idx       = r_idx;

        o_cmd              = '0;
        o_cmd.lane_en      = lane_mask;
        o_cmd.idx          = r_idx;
        o_cmd.tol          = r_cfg_tol;
        o_cmd.upd_bounds   = r_upd;
        o_cmd.sck          = r_clk_lvl;
        o_cmd.last         = 1'b1;

        case (r_state)
            ST_TICK: begin
                o_cmd.sck = tk_clk;
                if (accept) begin
                    n_phase     = tk_phase;
                    n_clk_lvl   = tk_clk;
                    n_bit_cnt   = tk_bit;
                    n_pulse_cnt = tk_pulse;
                    n_pd        = tk_pd;
                    o_cmd.shift        = tk_shift;
                    o_cmd.clear_bounds = (i_req == REQ_TARE);
                    if (tk_fin) begin
                        n_upd            = act_eff;
                        n_done           = tk_done;
                        n_tare_act       = act_eff && !tk_done;
                        n_tare_rem       = act_eff ? rem_dec : rem_eff;
                        n_idx            = '0;
                        n_state          = ST_SCAN;
                        o_cmd.clear_fail = 1'b1;
                    end else begin
                        n_tare_act      = act_eff;
                        n_tare_rem      = rem_eff;
                        o_cmd.idle_load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan = 1'b1;
                if (r_idx == last_idx) begin
                    n_idx   = '0;
                    n_state = ST_EMIT;
                end else begin
                    n_idx = r_idx + CH_W'(1);
                end
            end
            ST_EMIT: begin
                o_cmd.tare_done = r_done;
                o_cmd.tare_ok   = tare_ok;
                o_cmd.last      = (r_idx == last_idx);
                if (i_stat.out_free) begin
                    o_cmd.emit_load = 1'b1;
                    o_cmd.wr_offset = tare_ok;
                    if (r_idx == last_idx) begin
                        n_idx   = '0;
                        n_state = ST_TICK;
                    end else begin
                        n_idx = r_idx + CH_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_TICK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_TICK;
            r_phase     <= PH_IDLE;
            r_clk_lvl   <= 1'b0;
            r_bit_cnt   <= '0;
            r_pulse_cnt <= '0;
            r_pd        <= 1'b0;
            r_tare_rem  <= '0;
            r_tare_act  <= 1'b0;
            r_done      <= 1'b0;
            r_upd       <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_clk_lvl   <= n_clk_lvl;
            r_bit_cnt   <= n_bit_cnt;
            r_pulse_cnt <= n_pulse_cnt;
            r_pd        <= n_pd;
            r_tare_rem  <= n_tare_rem;
            r_tare_act  <= n_tare_act;
            r_done      <= n_done;
            r_upd       <= n_upd;
            r_idx       <= n_idx;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lcadc_dp.sv
// datapath: per-channel shift words, offsets, tare bounds, spread check and
// the output register; driven by lcadc_ctrl commands, uses lcadc_pkg
`timescale 1ns / 1ps
`default_nettype none

module lcadc_dp import lcadc_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic [MAX_CHANNELS-1:0] i_lines,
    input  wire t_dp_cmd                 i_cmd,
    output t_dp_stat                     o_stat,
    input  wire logic                    i_m_tready,
    output logic                         o_valid,
    output logic                         o_sck,
    output logic                         o_sample_valid,
    output logic [CH_W-1:0]              o_channel,
    output logic [WEIGHT_W-1:0]          o_weight,
    output logic                         o_tare_done,
    output logic                         o_tare_ok,
    output logic                         o_last
);

    logic [DATA_BITS-1:0] r_shift [MAX_CHANNELS];
    logic [DATA_BITS-1:0] r_off   [MAX_CHANNELS];
    logic [DATA_BITS-1:0] r_min   [MAX_CHANNELS];
    logic [DATA_BITS-1:0] r_max   [MAX_CHANNELS];
    logic                 r_fail;
    logic                 r_valid;
    logic                 r_sck;
    logic                 r_sv;
    logic [CH_W-1:0]      r_ch;
    logic [WEIGHT_W-1:0]  r_w;
    logic                 r_done;
    logic                 r_ok;
    logic                 r_last;

    logic [DATA_BITS-1:0] raw;
    logic [DATA_BITS-1:0] off;
    logic [DATA_BITS-1:0] new_min;
    logic [DATA_BITS-1:0] new_max;
    logic [WEIGHT_W-1:0]  spread;
    logic [WEIGHT_W-1:0]  diff;
    logic                 over_tol;

    assign raw     = r_shift[i_cmd.idx];
    assign off     = r_off[i_cmd.idx];
    assign new_min = ($signed(raw) < $signed(r_min[i_cmd.idx])) ? raw : r_min[i_cmd.idx];
    assign new_max = ($signed(raw) > $signed(r_max[i_cmd.idx])) ? raw : r_max[i_cmd.idx];
    assign spread  = {new_max[DATA_BITS-1], new_max} - {new_min[DATA_BITS-1], new_min};
    assign over_tol = spread > WEIGHT_W'(i_cmd.tol);
    // offset and raw are both DATA_BITS signed, so the difference always fits
    assign diff    = {raw[DATA_BITS-1], raw} - {off[DATA_BITS-1], off};

    assign o_stat.out_free    = !r_valid || i_m_tready;
    assign o_stat.spread_fail = r_fail;

    // serial capture, msb first
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_CHANNELS; k++) begin
            if (i_cmd.shift && i_cmd.lane_en[k]) begin
                r_shift[k] <= {r_shift[k][DATA_BITS-2:0], i_lines[k]};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
                r_off[k] <= '0;
                r_min[k] <= BOUND_TOP;
                r_max[k] <= BOUND_BOT;
            end
            r_fail <= 1'b0;
        end else begin
            if (i_cmd.clear_bounds) begin
                for (int k = 0; k < MAX_CHANNELS; k++) begin
                    r_min[k] <= BOUND_TOP;
                    r_max[k] <= BOUND_BOT;
                end
            end
            if (i_cmd.clear_fail) begin
                r_fail <= 1'b0;
            end
            if (i_cmd.scan && i_cmd.upd_bounds) begin
                r_min[i_cmd.idx] <= new_min;
                r_max[i_cmd.idx] <= new_max;
                r_fail           <= r_fail | over_tol;
            end
            if (i_cmd.emit_load && i_cmd.wr_offset) begin
                r_off[i_cmd.idx] <= raw;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.idle_load || i_cmd.emit_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.idle_load) begin
            r_sck  <= i_cmd.sck;
            r_sv   <= 1'b0;
            r_ch   <= '0;
            r_w    <= '0;
            r_done <= 1'b0;
            r_ok   <= 1'b0;
            r_last <= 1'b1;
        end else if (i_cmd.emit_load) begin
            r_sck  <= i_cmd.sck;
            r_sv   <= 1'b1;
            r_ch   <= i_cmd.idx;
            r_w    <= diff;
            r_done <= i_cmd.tare_done;
            r_ok   <= i_cmd.tare_ok;
            r_last <= i_cmd.last;
        end
    end

    assign o_valid        = r_valid;
    assign o_sck          = r_sck;
    assign o_sample_valid = r_sv;
    assign o_channel      = r_ch;
    assign o_weight       = r_w;
    assign o_tare_done    = r_done;
    assign o_tare_ok      = r_ok;
    assign o_last         = r_last;

endmodule

`default_nettype wire

// File: rtl/multi_channel_load_cell_adc_reader_unit.sv
// channel     | signals                      | payload
// ------------+------------------------------+---------------------------------------------
// tick in     | i_s_tvalid/o_s_tready        | tuser req_type, tdata dout_lines
// result out  | o_m_tvalid/i_m_tready        | tuser sample_valid, tlast last, tdata rest
// config      | i_cfg_we/i_cfg_addr          | i_cfg_data, no read-back
//
// a tick that ends no conversion yields one result
// a tick that ends a conversion yields one result per active channel:
// one channel a cycle through the tare bounds, then one channel a cycle out unless stalled
// synchronous reset clears all control state, no clearing pass
// a tick is taken only in a cycle where the output register is empty or its
// result leaves; a stalled output holds the readings pass and the input
// top level of the load cell adc reader; joins lcadc_ctrl and lcadc_dp, uses lcadc_pkg
`timescale 1ns / 1ps
`default_nettype none

module multi_channel_load_cell_adc_reader_unit import lcadc_pkg::*; (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_we,
    input  wire logic [CFG_ADDR_W-1:0]  i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,   // [7:0] dout_lines
    input  wire logic [REQ_W-1:0]       i_s_tuser,   // [1:0] req_type
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,   // [0] sck_out, [3:1] channel,
                                                     // [28:4] weight_value, [29] tare_done,
                                                     // [30] tare_ok, [31] zero
    output logic                        o_m_tuser,   // [0] sample_valid
    output logic                        o_m_tlast
);

    t_dp_cmd             cmd;
    t_dp_stat            stat;
    logic                sck;
    logic [CH_W-1:0]     channel;
    logic [WEIGHT_W-1:0] weight;
    logic                tare_done;
    logic                tare_ok;

    lcadc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_req      (i_s_tuser),
        .i_lines    (i_s_tdata[MAX_CHANNELS-1:0]),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    lcadc_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_lines        (i_s_tdata[MAX_CHANNELS-1:0]),
        .i_cmd          (cmd),
        .o_stat         (stat),
        .i_m_tready     (i_m_tready),
        .o_valid        (o_m_tvalid),
        .o_sck          (sck),
        .o_sample_valid (o_m_tuser),
        .o_channel      (channel),
        .o_weight       (weight),
        .o_tare_done    (tare_done),
        .o_tare_ok      (tare_ok),
        .o_last         (o_m_tlast)
    );

    assign o_m_tdata = {1'b0, tare_ok, tare_done, weight, channel, sck};

endmodule

`default_nettype wire

// File: rtl/lcadc_chk.sv
// port-level checker for the load cell adc reader, bound to the top level
// uses only the top level ports
`timescale 1ns / 1ps
`default_nettype none

module lcadc_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_tready,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [31:0] o_m_tdata,
    input wire logic        o_m_tuser,
    input wire logic        o_m_tlast
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // a tick without a reading is always the last result of its transaction
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tlast)
        else $error("idle result without tlast");

    // no new tick while a readings pass is still going out
    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && i_m_tready && o_m_tuser && !o_m_tlast |-> !o_s_tready)
        else $error("input ready during readings pass");

    // tare ok only with tare done
    a_ok_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[30] |-> o_m_tdata[29])
        else $error("tare_ok without tare_done");

    // reset empties the output register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind multi_channel_load_cell_adc_reader_unit lcadc_chk u_lcadc_chk (.*);

`default_nettype wire
